### src/quaternion_to_euler_angles_defines.svh
// ----------------------------------------------------------------------------
// quaternion to euler angles: assertion macros
// shared assertion forms for the conversion pipeline
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// same-cycle implication, off during reset
`define QTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qte assertion failed");

// next-cycle implication, checked during reset too
`define QTE_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("qte assertion failed");

`endif

### src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// types, constants and helper functions of the quaternion to euler pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int INPUT_WIDTH_DEF = 16;
    localparam int CORDIC_ITER_DEF = 16;

    localparam int CW        = 40;
    localparam int AW        = 28;
    localparam int DIV_STEPS = 31;
    localparam int SQ_STEPS  = 31;

    localparam logic signed [33:0]   ONE_Q28       = 34'sd268435456;
    localparam logic signed [AW-1:0] ANGLE_QUARTER = 28'sd26353589;
    localparam logic signed [29:0]   OUT_HALF_PI   = 30'sd6434;
    localparam logic signed [29:0]   OUT_PI        = 30'sd12868;
    localparam logic signed [29:0]   OUT_TWO_PI    = 30'sd25736;
    localparam logic signed [13:0]   ELEV_POS      = 14'sd6434;
    localparam logic signed [13:0]   ELEV_NEG      = -14'sd6434;

    localparam logic signed [AW-1:0] ATAN_TAB [9] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
        28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536
    };

    typedef enum logic [1:0] {
        POLE_NONE = 2'd0,
        POLE_POS  = 2'd1,
        POLE_NEG  = 2'd2
    } t_pole;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] low;
        logic [30:0] quo;
        logic [32:0] den;
        logic        neg;
        logic        zero;
    } t_div;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] root;
        logic [61:0] rad;
    } t_sqrt;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } t_cordic;

    typedef struct packed {
        t_pole              pole;
        logic signed [33:0] hy;
        logic signed [33:0] hx;
        logic signed [33:0] by;
        logic signed [33:0] bx;
        logic signed [15:0] py;
        logic signed [15:0] pw;
    } t_side;

    function automatic logic signed [AW-1:0] atan_step(input int i);
        logic signed [AW-1:0] r;
        if (i < 9) begin
            r = ATAN_TAB[i[3:0]];
        end else if (i <= 24) begin
            r = AW'(1) << (24 - i);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic t_cordic prerotate(input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] x);
        t_cordic c;
        c.zero = (x == '0) && (y == '0);
        if (x[CW-1]) begin
            if (!y[CW-1]) begin
                c.x   = y;
                c.y   = -x;
                c.ang = ANGLE_QUARTER;
            end else begin
                c.x   = -y;
                c.y   = x;
                c.ang = -ANGLE_QUARTER;
            end
        end else begin
            c.x   = x;
            c.y   = y;
            c.ang = '0;
        end
        return c;
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [29:0] a,
                                                     input logic signed [29:0] lim);
        logic signed [29:0] r;
        r = (a + 30'sd2048) >>> 12;
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r[15:0];
    endfunction

endpackage

### src/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// attitude quaternion (Q1.14) to heading, elevation and bank (rad * 4096)
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted per cycle while the pipeline is not
// held. Most of its depth lies in the cell chains: 31 division cells forming
// 2s/n, 31 square-root cells, and CORDIC_ITERATIONS cells in each of three
// parallel cordic chains. The whole pipeline advances together; it holds
// while a result waits in the output register and the output side is not
// ready.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles #(
    parameter int INPUT_WIDTH       = qte_pkg::INPUT_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [INPUT_WIDTH-1:0] i_quat_w,
    input  logic signed [INPUT_WIDTH-1:0] i_quat_x,
    input  logic signed [INPUT_WIDTH-1:0] i_quat_y,
    input  logic signed [INPUT_WIDTH-1:0] i_quat_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_heading,
    output logic signed [13:0]            o_elevation,
    output logic signed [14:0]            o_bank,
    output logic [1:0]                    o_pole_case
);

    localparam int CW       = qte_pkg::CW;
    localparam int DS       = qte_pkg::DIV_STEPS;
    localparam int SQ       = qte_pkg::SQ_STEPS;
    localparam int SIDE_LEN = DS + 1 + SQ;
    localparam int NST      = DS + SQ + CORDIC_ITERATIONS + 6;

    logic               en;
    logic [NST-1:0]     r_vld;

    logic signed [INPUT_WIDTH-1:0] w_raw [4];
    logic signed [15:0]            w_ld  [4];

    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic signed [31:0] r_w2, r_x2, r_y2, r_z2, r_wx, r_yz, r_wz, r_xy, r_wy, r_xz;
    logic signed [15:0] r1_y, r1_w;
    logic signed [33:0] r_n, r_s2, r_hy, r_hx, r_by, r_bx;
    logic signed [15:0] r2_y, r2_w;

    logic [33:0]        s2abs;
    qte_pkg::t_div      w_div [DS+1];
    qte_pkg::t_side     n_side;
    qte_pkg::t_side     r_side [SIDE_LEN];

    logic [30:0]        tmag;
    logic signed [31:0] r_t;
    logic [61:0]        r_tsq;
    logic signed [31:0] r_tdl [SQ];
    qte_pkg::t_sqrt     w_sq [SQ+1];

    qte_pkg::t_side     side_end;
    qte_pkg::t_cordic   w_ch [CORDIC_ITERATIONS+1];
    qte_pkg::t_cordic   w_cb [CORDIC_ITERATIONS+1];
    qte_pkg::t_cordic   w_ce [CORDIC_ITERATIONS+1];
    qte_pkg::t_pole     r_pdl [CORDIC_ITERATIONS+1];

    logic signed [29:0] ang_h, ang_b, ang_e;
    logic signed [15:0] n_heading, r_heading;
    logic signed [13:0] n_elevation, r_elevation;
    logic signed [14:0] n_bank, r_bank;
    qte_pkg::t_pole     r_pole;

    // pipeline control
    assign en         = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // input scaling to Q1.14
    assign w_raw[0] = i_quat_w;
    assign w_raw[1] = i_quat_x;
    assign w_raw[2] = i_quat_y;
    assign w_raw[3] = i_quat_z;

    for (genvar g = 0; g < 4; g++) begin : g_load
        if (INPUT_WIDTH > 16) begin : g_wide
            assign w_ld[g] = 16'(w_raw[g] >>> (INPUT_WIDTH - 16));
        end else if (INPUT_WIDTH == 16) begin : g_same
            assign w_ld[g] = w_raw[g];
        end else begin : g_narrow
            assign w_ld[g] = {w_raw[g], {(16 - INPUT_WIDTH){1'b0}}};
        end
    end

    // products and sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w  <= w_ld[0];
            r_x  <= w_ld[1];
            r_y  <= w_ld[2];
            r_z  <= w_ld[3];
            r_w2 <= r_w * r_w;
            r_x2 <= r_x * r_x;
            r_y2 <= r_y * r_y;
            r_z2 <= r_z * r_z;
            r_wx <= r_w * r_x;
            r_yz <= r_y * r_z;
            r_wz <= r_w * r_z;
            r_xy <= r_x * r_y;
            r_wy <= r_w * r_y;
            r_xz <= r_x * r_z;
            r1_y <= r_y;
            r1_w <= r_w;
            r_n  <= 34'(r_w2) + 34'(r_x2) + 34'(r_y2) + 34'(r_z2);
            r_s2 <= (34'(r_wx) + 34'(r_yz)) <<< 1;
            r_hy <= (34'(r_wz) - 34'(r_xy)) <<< 1;
            r_hx <= qte_pkg::ONE_Q28 - ((34'(r_z2) + 34'(r_x2)) <<< 1);
            r_by <= (34'(r_wy) - 34'(r_xz)) <<< 1;
            r_bx <= qte_pkg::ONE_Q28 - ((34'(r_y2) + 34'(r_x2)) <<< 1);
            r2_y <= r1_y;
            r2_w <= r1_w;
        end
    end

    // division setup and pole decision
    always_comb begin
        s2abs          = r_s2[33] ? 34'(-r_s2) : 34'(r_s2);
        w_div[0].rem   = s2abs[33:1];
        w_div[0].low   = {s2abs[0], 30'b0};
        w_div[0].quo   = '0;
        w_div[0].den   = r_n[32:0];
        w_div[0].neg   = r_s2[33];
        w_div[0].zero  = (r_n == '0);
        n_side.hy      = r_hy;
        n_side.hx      = r_hx;
        n_side.by      = r_by;
        n_side.bx      = r_bx;
        n_side.py      = r2_y;
        n_side.pw      = r2_w;
        priority if (r_s2 > r_n) begin
            n_side.pole = qte_pkg::POLE_POS;
        end else if (r_s2 < -r_n) begin
            n_side.pole = qte_pkg::POLE_NEG;
        end else begin
            n_side.pole = qte_pkg::POLE_NONE;
        end
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        qte_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_div[k]),
            .o_d   (w_div[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ratio and its square
    assign tmag = w_div[DS].zero ? '0 : w_div[DS].quo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t   <= w_div[DS].neg ? -32'(tmag) : 32'(tmag);
            r_tsq <= tmag * tmag;
        end
    end

    // square root of 2^60 - t^2
    assign w_sq[0].rem  = '0;
    assign w_sq[0].root = '0;
    assign w_sq[0].rad  = (62'd1 << 60) - r_tsq;

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_sq[k]),
            .o_d   (w_sq[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdl[0] <= r_t;
            for (int k = 1; k < SQ; k++) begin
                r_tdl[k] <= r_tdl[k-1];
            end
        end
    end

    // quadrant fold into the cordic chains
    assign side_end = r_side[SIDE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (side_end.pole != qte_pkg::POLE_NONE) begin
                w_ch[0] <= qte_pkg::prerotate(CW'(side_end.py), CW'(side_end.pw));
            end else begin
                w_ch[0] <= qte_pkg::prerotate(CW'(side_end.hy), CW'(side_end.hx));
            end
            w_cb[0]  <= qte_pkg::prerotate(CW'(side_end.by), CW'(side_end.bx));
            w_ce[0]  <= qte_pkg::prerotate(CW'(r_tdl[SQ-1]), CW'({1'b0, w_sq[SQ].root}));
            r_pdl[0] <= side_end.pole;
            for (int k = 1; k <= CORDIC_ITERATIONS; k++) begin
                r_pdl[k] <= r_pdl[k-1];
            end
        end
    end

    for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_cordic
        qte_cordic_cell #(.IDX(k)) u_head (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_ch[k]),
            .o_d   (w_ch[k+1])
        );
        qte_cordic_cell #(.IDX(k)) u_bank (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_cb[k]),
            .o_d   (w_cb[k+1])
        );
        qte_cordic_cell #(.IDX(k)) u_elev (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_ce[k]),
            .o_d   (w_ce[k+1])
        );
    end

    // rounding, saturation and pole selection
    always_comb begin
        ang_h = w_ch[CORDIC_ITERATIONS].zero ? '0 : 30'(w_ch[CORDIC_ITERATIONS].ang);
        ang_b = w_cb[CORDIC_ITERATIONS].zero ? '0 : 30'(w_cb[CORDIC_ITERATIONS].ang);
        ang_e = w_ce[CORDIC_ITERATIONS].zero ? '0 : 30'(w_ce[CORDIC_ITERATIONS].ang);
        unique case (r_pdl[CORDIC_ITERATIONS])
            qte_pkg::POLE_POS: begin
                n_heading   = qte_pkg::round_sat(ang_h <<< 1, qte_pkg::OUT_TWO_PI);
                n_elevation = qte_pkg::ELEV_POS;
                n_bank      = '0;
            end
            qte_pkg::POLE_NEG: begin
                n_heading   = qte_pkg::round_sat(-(ang_h <<< 1), qte_pkg::OUT_TWO_PI);
                n_elevation = qte_pkg::ELEV_NEG;
                n_bank      = '0;
            end
            default: begin
                n_heading   = qte_pkg::round_sat(ang_h, qte_pkg::OUT_PI);
                n_elevation = 14'(qte_pkg::round_sat(ang_e, qte_pkg::OUT_HALF_PI));
                n_bank      = 15'(qte_pkg::round_sat(ang_b, qte_pkg::OUT_PI));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_heading   <= n_heading;
            r_elevation <= n_elevation;
            r_bank      <= n_bank;
            r_pole      <= r_pdl[CORDIC_ITERATIONS];
        end
    end

    assign o_out_valid = r_vld[NST-1];
    assign o_heading   = r_heading;
    assign o_elevation = r_elevation;
    assign o_bank      = r_bank;
    assign o_pole_case = r_pole;

    `QTE_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)
    `QTE_ASSERT_IMP(a_pole_bank, i_clk, i_rst_n,
        o_out_valid && o_pole_case != qte_pkg::POLE_NONE, o_bank == '0)
    `QTE_ASSERT_IMP(a_pos_elev, i_clk, i_rst_n,
        o_out_valid && o_pole_case == qte_pkg::POLE_POS, o_elevation == qte_pkg::ELEV_POS)
    `QTE_ASSERT_IMP(a_elev_range, i_clk, i_rst_n, o_out_valid,
        o_elevation <= qte_pkg::ELEV_POS && o_elevation >= qte_pkg::ELEV_NEG)

endmodule

### src/qte_div_cell.sv
// ----------------------------------------------------------------------------
// qte_div_cell
// one restoring division step, one quotient bit per cycle while enabled
// ----------------------------------------------------------------------------
module qte_div_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  qte_pkg::t_div   i_d,
    output qte_pkg::t_div   o_d
);

    qte_pkg::t_div r_d;
    qte_pkg::t_div n_d;
    logic [33:0]   rem2;
    logic [33:0]   diff;
    logic          ge;

    always_comb begin
        rem2       = {i_d.rem, i_d.low[30]};
        diff       = rem2 - {1'b0, i_d.den};
        ge         = rem2 >= {1'b0, i_d.den};
        n_d        = i_d;
        n_d.rem    = ge ? diff[32:0] : rem2[32:0];
        n_d.low    = {i_d.low[29:0], 1'b0};
        n_d.quo    = {i_d.quo[29:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

### src/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// one digit-by-digit integer square root step, one root bit per cycle while enabled
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  qte_pkg::t_sqrt  i_d,
    output qte_pkg::t_sqrt  o_d
);

    qte_pkg::t_sqrt r_d;
    qte_pkg::t_sqrt n_d;
    logic [34:0]    rem2;
    logic [34:0]    trial;
    logic [34:0]    diff;
    logic           ge;

    always_comb begin
        rem2     = {i_d.rem, i_d.rad[61:60]};
        trial    = {2'b00, i_d.root, 2'b01};
        diff     = rem2 - trial;
        ge       = rem2 >= trial;
        n_d.rem  = ge ? diff[32:0] : rem2[32:0];
        n_d.root = {i_d.root[29:0], ge};
        n_d.rad  = {i_d.rad[59:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

### src/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring cordic micro-rotation with its arctangent step
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  qte_pkg::t_cordic  i_d,
    output qte_pkg::t_cordic  o_d
);

    localparam logic signed [qte_pkg::AW-1:0] STEP = qte_pkg::atan_step(IDX);

    qte_pkg::t_cordic            r_d;
    qte_pkg::t_cordic            n_d;
    logic signed [qte_pkg::CW-1:0] xs;
    logic signed [qte_pkg::CW-1:0] ys;

    always_comb begin
        xs       = i_d.x >>> IDX;
        ys       = i_d.y >>> IDX;
        n_d.zero = i_d.zero;
        if (!i_d.y[qte_pkg::CW-1]) begin
            n_d.x   = i_d.x + ys;
            n_d.y   = i_d.y - xs;
            n_d.ang = i_d.ang + STEP;
        end else begin
            n_d.x   = i_d.x - ys;
            n_d.y   = i_d.y + xs;
            n_d.ang = i_d.ang - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

### tb/quaternion_to_euler_angles_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// drives attitude quaternions through the conversion pipeline under several
// idle and stall patterns, predicts heading, elevation, bank and pole case
// with a bit-exact cordic model and checks every result in order
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;

    localparam int ITERS      = 16;
    localparam int LATENCY    = ITERS + 68;
    localparam int DOG_LIMIT  = 5000;
    localparam int HOLD_LEN   = 400;
    localparam int NUM_RANDOM = 150;

    typedef struct {
        logic signed [15:0] heading;
        logic signed [13:0] elevation;
        logic signed [14:0] bank;
        qte_pkg::t_pole     pole;
    } t_angles;

    typedef struct {
        int  w;
        int  x;
        int  y;
        int  z;
        bit  typed;
        qte_pkg::t_pole pole;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_quat_w;
    logic signed [15:0] i_quat_x;
    logic signed [15:0] i_quat_y;
    logic signed [15:0] i_quat_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_heading;
    logic signed [13:0] o_elevation;
    logic signed [14:0] o_bank;
    logic [1:0]         o_pole_case;

    t_angles angles_q[$];
    int      typed_pole_q[$];
    int      fail_count;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_left;

    quaternion_to_euler_angles uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_quat_w    (i_quat_w),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_heading   (o_heading),
        .o_elevation (o_elevation),
        .o_bank      (o_bank),
        .o_pole_case (o_pole_case)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint cordic_angle(longint y, longint x);
        longint ang;
        longint t;
        longint xs;
        longint ys;
        longint step;
        ang = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; ang = qte_pkg::ANGLE_QUARTER;
            end else begin
                t = x; x = -y; y = t; ang = -qte_pkg::ANGLE_QUARTER;
            end
        end
        for (int i = 0; i < ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (i < 9) step = qte_pkg::ATAN_TAB[i];
            else if (i <= 24) step = longint'(1) << (24 - i);
            else step = 0;
            if (y >= 0) begin
                x += ys; y -= xs; ang += step;
            end else begin
                x -= ys; y += xs; ang -= step;
            end
        end
        return ang;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint scale_sat(longint a, longint lim);
        longint r;
        r = (a + 2048) >>> 12;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                         logic signed [15:0] qy, logic signed [15:0] qz);
        t_angles a;
        longint w;
        longint x;
        longint y;
        longint z;
        longint n;
        longint s2;
        longint t;
        longint c;
        w = qw; x = qx; y = qy; z = qz;
        n  = w * w + x * x + y * y + z * z;
        s2 = 2 * (w * x + y * z);
        if (s2 > n) begin
            a.pole      = qte_pkg::POLE_POS;
            a.heading   = 16'(scale_sat(2 * cordic_angle(y, w), qte_pkg::OUT_TWO_PI));
            a.elevation = qte_pkg::ELEV_POS;
            a.bank      = '0;
        end else if (s2 < -n) begin
            a.pole      = qte_pkg::POLE_NEG;
            a.heading   = 16'(scale_sat(-2 * cordic_angle(y, w), qte_pkg::OUT_TWO_PI));
            a.elevation = qte_pkg::ELEV_NEG;
            a.bank      = '0;
        end else begin
            a.pole    = qte_pkg::POLE_NONE;
            a.heading = 16'(scale_sat(cordic_angle(2 * (w * z - x * y),
                                      qte_pkg::ONE_Q28 - 2 * (z * z + x * x)),
                                      qte_pkg::OUT_PI));
            a.bank    = 15'(scale_sat(cordic_angle(2 * (w * y - x * z),
                                      qte_pkg::ONE_Q28 - 2 * (y * y + x * x)),
                                      qte_pkg::OUT_PI));
            t = 0;
            if (n > 0) t = (s2 * (longint'(1) << 30)) / n;
            c = int_sqrt((64'd1 << 60) - longint'(t * t));
            a.elevation = 14'(scale_sat(cordic_angle(t, c), qte_pkg::OUT_HALF_PI));
        end
        return a;
    endfunction

    // scoreboard and watchdog
    always @(posedge i_clk) begin
        t_angles exp_a;
        int      tp;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_in_valid && o_in_ready) begin
                exp_a = euler_of(i_quat_w, i_quat_x, i_quat_y, i_quat_z);
                tp = typed_pole_q.pop_front();
                if (tp >= 0) exp_a.pole = qte_pkg::t_pole'(tp);
                angles_q.push_back(exp_a);
            end
            if (o_out_valid && i_out_ready) begin
                if (angles_q.size() == 0) begin
                    $error("result with no item pending");
                    fail_count++;
                end else begin
                    exp_a = angles_q.pop_front();
                    if (o_heading !== exp_a.heading) begin
                        $error("heading expected %0d got %0d", exp_a.heading, o_heading);
                        fail_count++;
                    end
                    if (o_elevation !== exp_a.elevation) begin
                        $error("elevation expected %0d got %0d", exp_a.elevation,
                               o_elevation);
                        fail_count++;
                    end
                    if (o_bank !== exp_a.bank) begin
                        $error("bank expected %0d got %0d", exp_a.bank, o_bank);
                        fail_count++;
                    end
                    if (o_pole_case !== exp_a.pole) begin
                        $error("pole_case expected %0d got %0d", exp_a.pole, o_pole_case);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= DOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // output side
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(int w, int x, int y, int z, int tp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_pole_q.push_back(tp);
        i_in_valid <= 1'b1;
        i_quat_w   <= 16'(w);
        i_quat_x   <= 16'(x);
        i_quat_y   <= 16'(y);
        i_quat_z   <= 16'(z);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic int rand_comp();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(32768) - 16384;
        if (r < 90) return $urandom_range(65535) - 32768;
        case ($urandom_range(4))
            0: return 16384;
            1: return -16384;
            2: return 0;
            3: return -32768;
            default: return 32767;
        endcase
    endfunction

    task automatic send_random(int count);
        int w;
        int x;
        int y;
        int z;
        real m;
        for (int i = 0; i < count; i++) begin
            w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
            // most items near unit norm, the rest raw
            if ($urandom_range(99) < 60) begin
                m = $sqrt(real'(w) * w + real'(x) * x + real'(y) * y + real'(z) * z);
                if (m > 0.0) begin
                    w = int'(w * 16384.0 / m); x = int'(x * 16384.0 / m);
                    y = int'(y * 16384.0 / m); z = int'(z * 16384.0 / m);
                end
            end
            send_item(w, x, y, z, -1);
        end
    endtask

    task automatic drain();
        while (angles_q.size() != 0) @(posedge i_clk);
    endtask

    t_row rows[20] = '{
        '{16384, 0, 0, 0, 1, qte_pkg::POLE_NONE},
        '{0, 0, 0, 0, 1, qte_pkg::POLE_NONE},
        '{0, 16384, 0, 0, 1, qte_pkg::POLE_NONE},
        '{0, 0, 16384, 0, 1, qte_pkg::POLE_NONE},
        '{0, 0, 0, 16384, 1, qte_pkg::POLE_NONE},
        '{-16384, 0, 0, 0, 1, qte_pkg::POLE_NONE},
        '{0, -16384, 0, 0, 1, qte_pkg::POLE_NONE},
        '{0, 0, -16384, 0, 1, qte_pkg::POLE_NONE},
        '{0, 0, 0, -16384, 1, qte_pkg::POLE_NONE},
        '{16384, 16384, 0, 0, 1, qte_pkg::POLE_NONE},
        '{16384, -16384, 0, 0, 1, qte_pkg::POLE_NONE},
        '{0, 0, 16384, 16384, 1, qte_pkg::POLE_NONE},
        '{11585, 11585, 0, 0, 1, qte_pkg::POLE_NONE},
        '{11585, 0, 11585, 0, 1, qte_pkg::POLE_NONE},
        '{11585, 0, 0, 11585, 1, qte_pkg::POLE_NONE},
        '{8192, 8192, 8192, 8192, 1, qte_pkg::POLE_NONE},
        '{-32768, -32768, -32768, -32768, 1, qte_pkg::POLE_NONE},
        '{32767, 32767, 32767, 32767, 1, qte_pkg::POLE_NONE},
        '{-32768, 32767, -32768, 32767, 1, qte_pkg::POLE_NONE},
        '{1, -1, 1, -1, 0, qte_pkg::POLE_NONE}
    };

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_quat_w       = '0;
        i_quat_x       = '0;
        i_quat_y       = '0;
        i_quat_z       = '0;
        fail_count     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_item(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                      rows[i].typed ? int'(rows[i].pole) : -1);
        end
        i_in_valid <= 1'b0;
        drain();

        // long receiver hold while items keep coming
        hold_left = HOLD_LEN;
        send_random(NUM_RANDOM);

        send_idle_pct = 75;
        send_random(NUM_RANDOM);

        send_idle_pct  = 0;
        recv_stall_pct = 75;
        send_random(NUM_RANDOM);

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_random(NUM_RANDOM);

        i_in_valid <= 1'b0;
        drain();
        repeat (LATENCY + 16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
